// ===== hdl/tta_pkg.sv =====
// Shared constants, types and swizzle helpers for the tiled texture address generator.
// No dependencies; every other file refers to it by scoped names.
package tta_pkg;

  // Payload and register widths
  localparam int COORD_BITS  = 14;
  localparam int OFFSET_BITS = 40;
  localparam int BSM_W       = 2;
  localparam int ESL_W       = 3;
  localparam int BASE_W      = 40;
  localparam int BPR_W       = 15;
  localparam int TAIL_W      = 10;
  localparam int MIPW_W      = 15;
  localparam int SURF_W      = 40;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 40;

  // Datapath widths
  localparam int SWZ_W    = 16;
  localparam int BLOG_W   = 5;
  localparam int EXT_W    = 4;
  localparam int PROD_W   = COORD_BITS + BPR_W;
  localparam int BLK_W    = PROD_W + 1;
  localparam int SHB_W    = BLK_W + 16;
  localparam int FULL_A   = (SHB_W > OFFSET_BITS) ? SHB_W : OFFSET_BITS;
  localparam int FULL_B   = (FULL_A > BASE_W) ? FULL_A : BASE_W;
  localparam int FULL_C   = (FULL_B > SURF_W) ? FULL_B : SURF_W;
  localparam int FULL_W   = FULL_C + 2;
  localparam int LPROD_W  = COORD_BITS + MIPW_W;
  localparam int LIN_W    = LPROD_W + 1 + 4;
  localparam int LIN_EXT  = (LIN_W > OFFSET_BITS) ? LIN_W : OFFSET_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BLOCK_SIZE_MODE   = 3'd0,
    CFG_ELEMENT_SIZE_LOG2 = 3'd1,
    CFG_BASE_OFFSET       = 3'd2,
    CFG_BLOCKS_PER_ROW    = 3'd3,
    CFG_TAIL_X_OFFSET     = 3'd4,
    CFG_TAIL_Y_OFFSET     = 3'd5,
    CFG_MIP_WIDTH         = 3'd6,
    CFG_SURFACE_SIZE      = 3'd7
  } cfg_idx_t;

  typedef enum logic [BSM_W-1:0] {
    MODE_256B = 2'd0,
    MODE_4KB  = 2'd1,
    MODE_64KB = 2'd2
  } block_mode_t;

  localparam logic [ESL_W-1:0] MAX_ELOG2 = 3'd4;

  // +n = x bit n-1, -n = y bit n-1, 0 = no source
  typedef logic signed [4:0] src_t;
  localparam src_t SWZ_SRC [0:4][0:15] = '{
    '{ 5'sd1, 5'sd2, 5'sd3, 5'sd4, -5'sd1, -5'sd2, -5'sd3, -5'sd4,
       -5'sd5, 5'sd5, -5'sd6, 5'sd6, -5'sd7, 5'sd7, -5'sd8, 5'sd8 },
    '{ 5'sd0, 5'sd1, 5'sd2, 5'sd3, -5'sd1, -5'sd2, -5'sd3, 5'sd4,
       -5'sd4, 5'sd5, -5'sd5, 5'sd6, -5'sd6, 5'sd7, -5'sd7, 5'sd8 },
    '{ 5'sd0, 5'sd0, 5'sd1, 5'sd2, -5'sd1, -5'sd2, -5'sd3, 5'sd3,
       -5'sd4, 5'sd4, -5'sd5, 5'sd5, -5'sd6, 5'sd6, -5'sd7, 5'sd7 },
    '{ 5'sd0, 5'sd0, 5'sd0, 5'sd1, -5'sd1, -5'sd2, 5'sd2, 5'sd3,
       -5'sd3, 5'sd4, -5'sd4, 5'sd5, -5'sd5, 5'sd6, -5'sd6, 5'sd7 },
    '{ 5'sd0, 5'sd0, 5'sd0, 5'sd0, -5'sd1, -5'sd2, 5'sd1, 5'sd2,
       -5'sd3, 5'sd3, -5'sd4, 5'sd4, -5'sd5, 5'sd5, -5'sd6, 5'sd6 }
  };

  // Block size log2; the unused mode saturates to 64 KB
  function automatic logic [BLOG_W-1:0] blk_log2(input logic [BSM_W-1:0] mode);
    logic [BLOG_W-1:0] r;
    case (block_mode_t'(mode))
      MODE_256B: r = 5'd8;
      MODE_4KB:  r = 5'd12;
      default:   r = 5'd16;
    endcase
    return r;
  endfunction

  // Element size log2 clamped to 16 bytes
  function automatic logic [ESL_W-1:0] elem_log2(input logic [ESL_W-1:0] v);
    return (v > MAX_ELOG2) ? MAX_ELOG2 : v;
  endfunction

  // Widest x (want_y = 0) or y (want_y = 1) bit used inside a block
  function automatic logic [EXT_W-1:0] ext_log2(input logic [ESL_W-1:0] e,
                                                input logic [BLOG_W-1:0] bl,
                                                input logic want_y);
    logic [EXT_W-1:0] best;
    src_t             s;
    logic [4:0]       mag;
    best = '0;
    for (int b = 0; b < SWZ_W; b++) begin
      s   = SWZ_SRC[e][b];
      mag = s[4] ? 5'(-s) : 5'(s);
      if (5'(b) >= {2'b00, e} && 5'(b) < bl && s != 5'sd0 && s[4] == want_y &&
          mag[EXT_W-1:0] > best) begin
        best = mag[EXT_W-1:0];
      end
    end
    return best;
  endfunction

  // Bit-interleave pattern of the low eight coordinate bits
  function automatic logic [SWZ_W-1:0] swizzle(input logic [ESL_W-1:0] e,
                                               input logic [BLOG_W-1:0] bl,
                                               input logic [7:0] sx,
                                               input logic [7:0] sy);
    logic [SWZ_W-1:0] acc;
    src_t             s;
    logic [4:0]       mag;
    logic [4:0]       idx;
    acc = '0;
    for (int b = 0; b < SWZ_W; b++) begin
      s   = SWZ_SRC[e][b];
      mag = s[4] ? 5'(-s) : 5'(s);
      idx = mag - 5'd1;
      if (5'(b) >= {2'b00, e} && 5'(b) < bl && s != 5'sd0) begin
        acc[b] = s[4] ? sy[idx[2:0]] : sx[idx[2:0]];
      end
    end
    return acc;
  endfunction

endpackage

// ===== hdl/tta_in_if.sv =====
// Coordinate input channel: valid/ready plus one element coordinate.
// Depends on tta_pkg for the coordinate width.
interface tta_in_if;
  logic                           valid;
  logic                           ready;
  logic [tta_pkg::COORD_BITS-1:0] col;
  logic [tta_pkg::COORD_BITS-1:0] row;

  modport source (output valid, col, row, input ready);
  modport sink   (input valid, col, row, output ready);
endinterface

// ===== hdl/tta_out_if.sv =====
// Address result channel: valid/ready plus tiled offset, linear offset and range flag.
// Depends on tta_pkg for the offset width.
interface tta_out_if;
  logic                            valid;
  logic                            ready;
  logic [tta_pkg::OFFSET_BITS-1:0] tiled_offset;
  logic [tta_pkg::OFFSET_BITS-1:0] linear_offset;
  logic                            out_of_range;

  modport source (output valid, tiled_offset, linear_offset, out_of_range, input ready);
  modport sink   (input valid, tiled_offset, linear_offset, out_of_range, output ready);
endinterface

// ===== hdl/tta_cfg_if.sv =====
// Configuration write channel: valid/ready, register index and write data.
// Depends on tta_pkg for the index and data widths.
interface tta_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tta_pkg::CFG_IDX_W-1:0]  index;
  logic [tta_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== hdl/tiled_texture_address_generator.sv =====
// Tiled texture address generator: standard swizzle block addressing, linear offset
// and surface range check. Depends on tta_pkg and the tta_in_if/tta_out_if/tta_cfg_if
// interfaces.
//
//  channel  | dir | transfer payload                                | handshake
//  ---------+-----+-------------------------------------------------+-------------
//  in_ch    | in  | col, row                                        | valid/ready
//  out_ch   | out | tiled_offset, linear_offset, out_of_range       | valid/ready
//  cfg_ch   | in  | index (register number), data                   | valid/ready
//
// Cycles: one coordinate transfer per clock sustained while out_ch.ready is high;
//   after the input transfer the result moves through the input reg and the multiply
//   stage reg, and the add/compare stage feeds the output register it transfers from.
// The two 14x15 multipliers (block row, linear row) set the middle stage; the 48-bit
//   base/block add and range compare set the last.
// Reset: rst_n synchronous, active low; clears pipeline valids and loads register
//   reset values. cfg_ch is always ready.
// Stalls: each stage holds while the one after it is full and not draining, so
//   out_ch.ready low back-pressures in_ch through three registers without loss.
module tiled_texture_address_generator (
  input  logic clk,
  input  logic rst_n,
  tta_in_if.sink    in_ch,
  tta_out_if.source out_ch,
  tta_cfg_if.sink   cfg_ch
);

  localparam int CW = tta_pkg::COORD_BITS;
  localparam int OW = tta_pkg::OFFSET_BITS;

  // ---------------- configuration registers ----------------
  logic [tta_pkg::BSM_W-1:0]  block_size_mode_r;
  logic [tta_pkg::ESL_W-1:0]  element_size_log2_r;
  logic [tta_pkg::BASE_W-1:0] base_offset_r;
  logic [tta_pkg::BPR_W-1:0]  blocks_per_row_r;
  logic [tta_pkg::TAIL_W-1:0] tail_x_offset_r;
  logic [tta_pkg::TAIL_W-1:0] tail_y_offset_r;
  logic [tta_pkg::MIPW_W-1:0] mip_width_r;
  logic [tta_pkg::SURF_W-1:0] surface_size_r;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_mode_r   <= tta_pkg::BSM_W'(tta_pkg::MODE_4KB);
      element_size_log2_r <= '0;
      base_offset_r       <= '0;
      blocks_per_row_r    <= tta_pkg::BPR_W'(1);
      tail_x_offset_r     <= '0;
      tail_y_offset_r     <= '0;
      mip_width_r         <= tta_pkg::MIPW_W'(1);
      surface_size_r      <= '0;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (tta_pkg::cfg_idx_t'(cfg_ch.index))
        tta_pkg::CFG_BLOCK_SIZE_MODE:   block_size_mode_r   <= cfg_ch.data[tta_pkg::BSM_W-1:0];
        tta_pkg::CFG_ELEMENT_SIZE_LOG2: element_size_log2_r <= cfg_ch.data[tta_pkg::ESL_W-1:0];
        tta_pkg::CFG_BASE_OFFSET:       base_offset_r       <= cfg_ch.data[tta_pkg::BASE_W-1:0];
        tta_pkg::CFG_BLOCKS_PER_ROW:    blocks_per_row_r    <= cfg_ch.data[tta_pkg::BPR_W-1:0];
        tta_pkg::CFG_TAIL_X_OFFSET:     tail_x_offset_r     <= cfg_ch.data[tta_pkg::TAIL_W-1:0];
        tta_pkg::CFG_TAIL_Y_OFFSET:     tail_y_offset_r     <= cfg_ch.data[tta_pkg::TAIL_W-1:0];
        tta_pkg::CFG_MIP_WIDTH:         mip_width_r         <= cfg_ch.data[tta_pkg::MIPW_W-1:0];
        tta_pkg::CFG_SURFACE_SIZE:      surface_size_r      <= cfg_ch.data[tta_pkg::SURF_W-1:0];
        default: ;
      endcase
    end
  end

  // Decoded block geometry; users write config only with the pipe empty; the block does not enforce it
  logic [tta_pkg::BLOG_W-1:0] blog2;
  logic [tta_pkg::ESL_W-1:0]  elog2;
  logic [tta_pkg::EXT_W-1:0]  wlog2;
  logic [tta_pkg::EXT_W-1:0]  hlog2;

  assign blog2 = tta_pkg::blk_log2(block_size_mode_r);
  assign elog2 = tta_pkg::elem_log2(element_size_log2_r);
  assign wlog2 = tta_pkg::ext_log2(elog2, blog2, 1'b0);
  assign hlog2 = tta_pkg::ext_log2(elog2, blog2, 1'b1);

  // ---------------- pipeline handshake ----------------
  logic s1_v_r, s2_v_r, out_v_r;
  logic out_free, s2_ready, s1_ready;

  assign out_free    = !out_v_r || out_ch.ready;
  assign s2_ready    = !s2_v_r || out_free;
  assign s1_ready    = !s1_v_r || s2_ready;
  assign in_ch.ready = s1_ready;

  // ---------------- stage 1: input register ----------------
  logic [CW-1:0] s1_col_r, s1_row_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_ready) begin
      s1_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && s1_ready) begin
      s1_col_r <= in_ch.col;
      s1_row_r <= in_ch.row;
    end
  end

  // ---------------- stage 2: multiplies and bit-interleave pattern ----------------
  logic [CW-1:0]                   row_sh_nxt, col_sh_nxt;
  logic [7:0]                      sx_nxt, sy_nxt;
  logic [tta_pkg::PROD_W-1:0]      bprod_nxt;
  logic [tta_pkg::LPROD_W-1:0]     lprod_nxt;
  logic [tta_pkg::SWZ_W-1:0]       swz_nxt;

  logic [CW-1:0]                   s2_col_r, s2_col_sh_r;
  logic [tta_pkg::PROD_W-1:0]      s2_bprod_r;
  logic [tta_pkg::LPROD_W-1:0]     s2_lprod_r;
  logic [tta_pkg::SWZ_W-1:0]       s2_swz_r;

  always_comb begin
    row_sh_nxt = s1_row_r >> hlog2;
    col_sh_nxt = s1_col_r >> wlog2;
    // tail offsets feed only the in-block pattern, low eight bits
    sx_nxt     = s1_col_r[7:0] + tail_x_offset_r[7:0];
    sy_nxt     = s1_row_r[7:0] + tail_y_offset_r[7:0];
    swz_nxt    = tta_pkg::swizzle(elog2, blog2, sx_nxt, sy_nxt);
    bprod_nxt  = tta_pkg::PROD_W'(row_sh_nxt) * tta_pkg::PROD_W'(blocks_per_row_r);
    lprod_nxt  = tta_pkg::LPROD_W'(s1_row_r) * tta_pkg::LPROD_W'(mip_width_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_ready) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_v_r && s2_ready) begin
      s2_col_r    <= s1_col_r;
      s2_col_sh_r <= col_sh_nxt;
      s2_bprod_r  <= bprod_nxt;
      s2_lprod_r  <= lprod_nxt;
      s2_swz_r    <= swz_nxt;
    end
  end

  // ---------------- stage 3: sums, range check, output register ----------------
  logic [tta_pkg::BLK_W-1:0]   blk_nxt;
  logic [tta_pkg::FULL_W-1:0]  full_nxt;
  logic [tta_pkg::FULL_W-1:0]  end_nxt;
  logic [tta_pkg::LIN_EXT-1:0] lin_nxt;
  logic                        oor_nxt;

  logic [OW-1:0] out_tiled_r, out_linear_r;
  logic          out_oor_r;

  always_comb begin
    blk_nxt  = tta_pkg::BLK_W'(s2_bprod_r) + tta_pkg::BLK_W'(s2_col_sh_r);
    full_nxt = tta_pkg::FULL_W'(base_offset_r)
             + (tta_pkg::FULL_W'(blk_nxt) << blog2)
             + tta_pkg::FULL_W'(s2_swz_r);
    // compare before wrap: a wrapped offset always reads out of range
    end_nxt  = full_nxt + (tta_pkg::FULL_W'(1) << elog2);
    oor_nxt  = end_nxt > tta_pkg::FULL_W'(surface_size_r);
    lin_nxt  = (tta_pkg::LIN_EXT'(s2_lprod_r) + tta_pkg::LIN_EXT'(s2_col_r)) << elog2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && out_free) begin
      out_tiled_r  <= full_nxt[OW-1:0];
      out_linear_r <= lin_nxt[OW-1:0];
      out_oor_r    <= oor_nxt;
    end
  end

  assign out_ch.valid         = out_v_r;
  assign out_ch.tiled_offset  = out_tiled_r;
  assign out_ch.linear_offset = out_linear_r;
  assign out_ch.out_of_range  = out_oor_r;

  // ---------------- assertions ----------------
  a_in_captured: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_v_r)
    else $error("accepted coordinate not captured in stage 1");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_v_r && !s2_ready) |=> (s1_v_r && $stable(s1_col_r) && $stable(s1_row_r)))
    else $error("stage 1 lost or changed a stalled coordinate");

  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s2_v_r))
    else $error("result appeared without an item in stage 2");

  a_s2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s2_v_r && !out_free) |=> (s2_v_r && $stable(s2_bprod_r) && $stable(s2_swz_r)))
    else $error("stage 2 lost or changed a stalled item");

endmodule
